### rtl/assert_macros.svh
// assertion macros shared by the gradient fill rtl
// expects clk_i and rst_ni in the scope where a macro is used
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every rising clock edge outside reset
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// condition must never be seen outside reset
`define ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

### rtl/ledgf_pkg.sv
// shared types and constants of the led gradient fill block
// no dependencies
`default_nettype none

package ledgf_pkg;

  localparam int unsigned PosW = 6;   // led index width
  localparam int unsigned ColW = 8;   // colour channel width
  localparam int unsigned WgtW = 11;  // mix weight, 0 .. 1024
  localparam int unsigned QueueDepth = 2;

  localparam logic [WgtW-1:0] MixOne = 11'd1024;

  // one run of pixel writes, as handed from front to back
  typedef struct packed {
    logic [ColW-1:0] a_red;    // colour at the reference stop
    logic [ColW-1:0] a_green;
    logic [ColW-1:0] a_blue;
    logic [ColW-1:0] b_red;    // colour at this stop
    logic [ColW-1:0] b_green;
    logic [ColW-1:0] b_blue;
    logic [PosW-1:0] l_pos;    // pixel before the first one written
    logic [PosW-1:0] p_pos;    // last pixel written
    logic [PosW-1:0] span;     // p_pos - l_pos, never zero
    logic [WgtW-1:0] q0;       // 1024 / span
    logic [PosW-1:0] r0;       // 1024 % span
  } run_cmd_t;

  typedef enum logic [1:0] {
    FE_IDLE,
    FE_DIV,
    FE_PUSH
  } front_state_e;

endpackage

`default_nettype wire

### rtl/led_gradient_fill_core.sv
// top level of the led gradient fill block
// depends on ledgf_pkg, ledgf_front, ledgf_queue and ledgf_back
//
// usage
//   input channel: one colour stop per word (frame start flag, led position,
//   red, green, blue) on in_valid_i / in_ready_o. output channel: one pixel
//   write per word (index, red, green, blue, last of run) on out_valid_o /
//   out_ready_i. a position at or beyond LED_COUNT is clamped to the last led.
//   stop handling
//   a frame start stop needs no division and goes straight to the run queue.
//   a later stop ahead of the previous one first passes the bit-serial
//   1024/span divider; the front end then takes the quotient and queues its
//   run, and the input is not ready again until that run is queued. the back
//   end emits one pixel per cycle while the receiver takes them, span words in
//   all, and loads the next run once the current one has ended. a stop at or
//   behind the previous one only moves the reference and gives no output. the
//   two entry run queue lets the divider work on the next stop while pixels of
//   the current run drain.
//   reset
//   the reference stop returns to position 0 in black; queue and output empty.
//   receiver stall
//   the output register holds its word; the back end stops, the queue fills
//   and then the input side stops taking stops.
`default_nettype none

module led_gradient_fill_core #(
  parameter int unsigned LED_COUNT = 64
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       in_valid_i,
  output logic                            in_ready_o,
  input  wire logic                       start_of_frame_i,
  input  wire logic [ledgf_pkg::PosW-1:0] stop_position_i,
  input  wire logic [ledgf_pkg::ColW-1:0] stop_red_i,
  input  wire logic [ledgf_pkg::ColW-1:0] stop_green_i,
  input  wire logic [ledgf_pkg::ColW-1:0] stop_blue_i,
  output logic                            out_valid_o,
  input  wire logic                       out_ready_i,
  output logic [ledgf_pkg::PosW-1:0]      pixel_index_o,
  output logic [ledgf_pkg::ColW-1:0]      red_out_o,
  output logic [ledgf_pkg::ColW-1:0]      green_out_o,
  output logic [ledgf_pkg::ColW-1:0]      blue_out_o,
  output logic                            last_of_run_o
);
  import ledgf_pkg::*;

  run_cmd_t push_cmd;
  run_cmd_t pop_cmd;
  logic     push;
  logic     full;
  logic     pop;
  logic     empty;

  // stop intake and divider
  ledgf_front #(
    .LED_COUNT (LED_COUNT)
  ) u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .start_of_frame_i (start_of_frame_i),
    .stop_position_i  (stop_position_i),
    .stop_red_i       (stop_red_i),
    .stop_green_i     (stop_green_i),
    .stop_blue_i      (stop_blue_i),
    .push_o           (push),
    .full_i           (full),
    .cmd_o            (push_cmd)
  );

  // run queue
  ledgf_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_cmd),
    .full_o      (full),
    .pop_i       (pop),
    .empty_o     (empty),
    .pop_data_o  (pop_cmd)
  );

  // pixel generation
  ledgf_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .empty_i       (empty),
    .cmd_i         (pop_cmd),
    .pop_o         (pop),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .pixel_index_o (pixel_index_o),
    .red_out_o     (red_out_o),
    .green_out_o   (green_out_o),
    .blue_out_o    (blue_out_o),
    .last_of_run_o (last_of_run_o)
  );

endmodule

`default_nettype wire

### rtl/ledgf_recip.sv
// iterative restoring divider for 1024 / span, one quotient bit a cycle
// depends on ledgf_pkg and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

module ledgf_recip (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       start_i,
  input  wire logic [ledgf_pkg::PosW-1:0] span_i,
  output logic                            done_o,
  output logic [ledgf_pkg::WgtW-1:0]      quo_o,
  output logic [ledgf_pkg::PosW-1:0]      rem_o
);
  import ledgf_pkg::*;

  localparam int unsigned CntW = $clog2(WgtW);

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic [PosW-1:0]   span_q, span_d;
  logic [PosW-1:0]   rem_q, rem_d;
  logic [WgtW-1:0]   quo_q, quo_d;
  logic [PosW:0]     shifted;
  logic              ge;
  logic              dbit;

  // dividend is a single one in its top bit
  assign dbit    = (cnt_q == CntW'(WgtW - 1));
  assign shifted = {rem_q, dbit};
  assign ge      = (shifted >= {1'b0, span_q});

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    span_d = span_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CntW'(WgtW - 1);
      span_d = span_i;
      rem_d  = '0;
      quo_d  = '0;
    end else if (busy_q) begin
      rem_d = ge ? PosW'(shifted - {1'b0, span_q}) : shifted[PosW-1:0];
      quo_d = {quo_q[WgtW-2:0], ge};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    cnt_q  <= cnt_d;
    span_q <= span_d;
    rem_q  <= rem_d;
    quo_q  <= quo_d;
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;
  assign rem_o  = rem_q;

  `ASSERT_CLK(a_rem_below_span, done_q |-> (rem_q < span_q), "remainder not below divisor")

endmodule

`default_nettype wire

### rtl/ledgf_front.sv
// front end: accepts stops, saturates, classifies and prepares a run command
// depends on ledgf_pkg and ledgf_recip
`default_nettype none

module ledgf_front #(
  parameter int unsigned LED_COUNT = 64
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       in_valid_i,
  output logic                            in_ready_o,
  input  wire logic                       start_of_frame_i,
  input  wire logic [ledgf_pkg::PosW-1:0] stop_position_i,
  input  wire logic [ledgf_pkg::ColW-1:0] stop_red_i,
  input  wire logic [ledgf_pkg::ColW-1:0] stop_green_i,
  input  wire logic [ledgf_pkg::ColW-1:0] stop_blue_i,
  output logic                            push_o,
  input  wire logic                       full_i,
  output ledgf_pkg::run_cmd_t             cmd_o
);
  import ledgf_pkg::*;

  localparam logic [PosW-1:0] MaxPos = PosW'(LED_COUNT - 1);

  front_state_e    state_q, state_d;
  logic [PosW-1:0] ref_pos_q;
  logic [ColW-1:0] ref_red_q, ref_green_q, ref_blue_q;
  run_cmd_t        cmd_q, cmd_d;
  logic            accept;
  logic [PosW-1:0] pos_sat;
  logic [PosW-1:0] span;
  logic            ahead;
  logic            div_start;
  logic            div_done;
  logic [WgtW-1:0] div_quo;
  logic [PosW-1:0] div_rem;

  assign accept    = in_valid_i && in_ready_o;
  assign pos_sat   = (stop_position_i > MaxPos) ? MaxPos : stop_position_i;
  assign span      = pos_sat - ref_pos_q;
  assign ahead     = (pos_sat > ref_pos_q);
  assign div_start = accept && !start_of_frame_i && ahead;

  ledgf_recip u_recip (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .span_i  (span),
    .done_o  (div_done),
    .quo_o   (div_quo),
    .rem_o   (div_rem)
  );

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      FE_IDLE: begin
        if (accept) begin
          if (start_of_frame_i) begin
            state_d = FE_PUSH;
          end else if (ahead) begin
            state_d = FE_DIV;
          end
        end
      end
      FE_DIV: begin
        if (div_done) begin
          state_d = FE_PUSH;
        end
      end
      FE_PUSH: begin
        if (!full_i) begin
          state_d = FE_IDLE;
        end
      end
      default: state_d = FE_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ready_o = 1'b0;
    push_o     = 1'b0;
    case (state_q)
      FE_IDLE: in_ready_o = 1'b1;
      FE_PUSH: push_o     = !full_i;
      default: ;
    endcase
  end

  // command build: a frame start is a one pixel run at full weight
  always_comb begin
    cmd_d = cmd_q;
    if (accept) begin
      cmd_d.b_red   = stop_red_i;
      cmd_d.b_green = stop_green_i;
      cmd_d.b_blue  = stop_blue_i;
      cmd_d.p_pos   = pos_sat;
      if (start_of_frame_i) begin
        cmd_d.a_red   = stop_red_i;
        cmd_d.a_green = stop_green_i;
        cmd_d.a_blue  = stop_blue_i;
        cmd_d.l_pos   = pos_sat - 1'b1;
        cmd_d.span    = PosW'(1);
        cmd_d.q0      = MixOne;
        cmd_d.r0      = '0;
      end else begin
        cmd_d.a_red   = ref_red_q;
        cmd_d.a_green = ref_green_q;
        cmd_d.a_blue  = ref_blue_q;
        cmd_d.l_pos   = ref_pos_q;
        cmd_d.span    = span;
      end
    end else if (state_q == FE_DIV && div_done) begin
      cmd_d.q0 = div_quo;
      cmd_d.r0 = div_rem;
    end
  end

  // state and reference stop
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= FE_IDLE;
      ref_pos_q   <= '0;
      ref_red_q   <= '0;
      ref_green_q <= '0;
      ref_blue_q  <= '0;
    end else begin
      state_q <= state_d;
      if (accept) begin
        ref_pos_q   <= pos_sat;
        ref_red_q   <= stop_red_i;
        ref_green_q <= stop_green_i;
        ref_blue_q  <= stop_blue_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d;
  end

  assign cmd_o = cmd_q;

endmodule

`default_nettype wire

### rtl/ledgf_queue.sv
// short command queue between front and back
// depends on ledgf_pkg and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

module ledgf_queue (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                push_i,
  input  wire ledgf_pkg::run_cmd_t push_data_i,
  output logic                     full_o,
  input  wire logic                pop_i,
  output logic                     empty_o,
  output ledgf_pkg::run_cmd_t      pop_data_o
);
  import ledgf_pkg::*;

  localparam int unsigned PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned CntW = $clog2(QueueDepth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(QueueDepth - 1);

  run_cmd_t        mem_q [QueueDepth];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [CntW-1:0] count_q;

  assign full_o     = (count_q == CntW'(QueueDepth));
  assign empty_o    = (count_q == '0);
  assign pop_data_o = mem_q[rd_q];

  // pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q    <= '0;
      rd_q    <= '0;
      count_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == LastPtr) ? '0 : wr_q + 1'b1;
      end
      if (pop_i) begin
        rd_q <= (rd_q == LastPtr) ? '0 : rd_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

  `ASSERT_NEVER(a_no_overflow, push_i && !pop_i && full_o, "push into full queue")
  `ASSERT_NEVER(a_no_underflow, pop_i && empty_o, "pop from empty queue")

endmodule

`default_nettype wire

### rtl/ledgf_back.sv
// back end: walks a run one pixel a cycle unless the output stalls, steps the weight and blends colours
// depends on ledgf_pkg and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

module ledgf_back (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       empty_i,
  input  wire ledgf_pkg::run_cmd_t        cmd_i,
  output logic                            pop_o,
  output logic                            out_valid_o,
  input  wire logic                       out_ready_i,
  output logic [ledgf_pkg::PosW-1:0]      pixel_index_o,
  output logic [ledgf_pkg::ColW-1:0]      red_out_o,
  output logic [ledgf_pkg::ColW-1:0]      green_out_o,
  output logic [ledgf_pkg::ColW-1:0]      blue_out_o,
  output logic                            last_of_run_o
);
  import ledgf_pkg::*;

  localparam int unsigned ProdW = ColW + 1 + WgtW + 1;

  // a + floor(w * (b - a) / 1024), equal to ((1024-w)*a + w*b) / 1024
  function automatic logic [ColW-1:0] blend(input logic [ColW-1:0] a,
                                            input logic [ColW-1:0] b,
                                            input logic [WgtW-1:0] w);
    logic signed [ColW:0]    diff;
    logic signed [ProdW-1:0] prod;
    logic signed [ProdW-1:0] sum;
    diff = $signed({1'b0, b}) - $signed({1'b0, a});
    prod = ProdW'(diff) * ProdW'($signed({1'b0, w}));
    sum  = $signed(ProdW'({1'b0, a})) + (prod >>> 10);
    return sum[ColW-1:0];
  endfunction

  logic            busy_q;
  logic [PosW-1:0] k_q, p_q, span_q, r_q, r0_q;
  logic [WgtW-1:0] w_q, q0_q;
  logic [ColW-1:0] a_red_q, a_green_q, a_blue_q;
  logic [ColW-1:0] b_red_q, b_green_q, b_blue_q;
  logic            out_valid_q;
  logic [PosW-1:0] pix_q;
  logic [ColW-1:0] red_q, green_q, blue_q;
  logic            last_q;
  logic            out_free;
  logic            advance;
  logic            at_end;
  logic [PosW:0]   r_sum;
  logic            wrap;
  logic [PosW-1:0] r_d;
  logic [WgtW-1:0] w_d;

  assign out_free = !out_valid_q || out_ready_i;
  assign advance  = busy_q && out_free;
  assign at_end   = (k_q == p_q);
  assign pop_o    = !busy_q && !empty_i;

  // weight step: add 1024/span, carry the remainder
  assign r_sum = {1'b0, r_q} + {1'b0, r0_q};
  assign wrap  = (r_sum >= {1'b0, span_q});
  assign r_d   = wrap ? PosW'(r_sum - {1'b0, span_q}) : r_sum[PosW-1:0];
  assign w_d   = w_q + q0_q + WgtW'(wrap);

  // run control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (pop_o) begin
        busy_q <= 1'b1;
      end else if (advance && at_end) begin
        busy_q <= 1'b0;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // run registers
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      k_q       <= cmd_i.l_pos + 1'b1;
      p_q       <= cmd_i.p_pos;
      span_q    <= cmd_i.span;
      w_q       <= cmd_i.q0;
      r_q       <= cmd_i.r0;
      q0_q      <= cmd_i.q0;
      r0_q      <= cmd_i.r0;
      a_red_q   <= cmd_i.a_red;
      a_green_q <= cmd_i.a_green;
      a_blue_q  <= cmd_i.a_blue;
      b_red_q   <= cmd_i.b_red;
      b_green_q <= cmd_i.b_green;
      b_blue_q  <= cmd_i.b_blue;
    end else if (advance) begin
      k_q <= k_q + 1'b1;
      w_q <= w_d;
      r_q <= r_d;
    end
  end

  // output word register
  always_ff @(posedge clk_i) begin
    if (advance) begin
      pix_q   <= k_q;
      red_q   <= blend(a_red_q, b_red_q, w_q);
      green_q <= blend(a_green_q, b_green_q, w_q);
      blue_q  <= blend(a_blue_q, b_blue_q, w_q);
      last_q  <= at_end;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign pixel_index_o = pix_q;
  assign red_out_o     = red_q;
  assign green_out_o   = green_q;
  assign blue_out_o    = blue_q;
  assign last_of_run_o = last_q;

  `ASSERT_CLK(a_full_weight_at_end, (busy_q && at_end) |-> (w_q == MixOne), "weight not full at run end")
  `ASSERT_CLK(a_run_ends, (advance && at_end) |=> !busy_q, "run continues past its last pixel")

endmodule

`default_nettype wire

### bench/led_gradient_fill_core_tb.sv
`timescale 1ns / 100ps
// self-checking bench for led_gradient_fill_core: colour stops in, pixel writes out
// depends on ledgf_pkg and the core; predicts every pixel write and checks each word

module led_gradient_fill_core_tb;

  import ledgf_pkg::*;

  localparam int unsigned LedCount    = 64;
  localparam int unsigned MixScale    = 1024;
  localparam int unsigned RandomStops = 260;
  localparam int unsigned TailCycles  = 40;
  localparam int unsigned CycleLimit  = 3000000;

  // one expected pixel write
  typedef struct packed {
    logic [PosW-1:0] index;
    logic [ColW-1:0] red;
    logic [ColW-1:0] green;
    logic [ColW-1:0] blue;
    logic            last_px;
  } pixel_write_t;

  logic            clk_i       = 1'b0;
  logic            rst_ni      = 1'b0;
  logic            in_valid    = 1'b0;
  logic            in_ready;
  logic            sof_in      = 1'b0;
  logic [PosW-1:0] pos_in      = '0;
  logic [ColW-1:0] red_in      = '0;
  logic [ColW-1:0] green_in    = '0;
  logic [ColW-1:0] blue_in     = '0;
  logic            out_valid;
  logic            out_ready   = 1'b0;
  logic [PosW-1:0] pixel_index;
  logic [ColW-1:0] red_out;
  logic [ColW-1:0] green_out;
  logic [ColW-1:0] blue_out;
  logic            last_of_run;

  // gradient reference stop, as the block should hold it
  logic [PosW-1:0] ref_pos;
  logic [ColW-1:0] ref_red;
  logic [ColW-1:0] ref_green;
  logic [ColW-1:0] ref_blue;

  pixel_write_t pending_pixels[$];
  int unsigned  fail_count  = 0;
  int unsigned  cycle_count = 0;
  int unsigned  ready_hold  = 0;
  logic         idle_en     = 1'b1;

  led_gradient_fill_core #(
    .LED_COUNT(LedCount)
  ) u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid),
    .in_ready_o      (in_ready),
    .start_of_frame_i(sof_in),
    .stop_position_i (pos_in),
    .stop_red_i      (red_in),
    .stop_green_i    (green_in),
    .stop_blue_i     (blue_in),
    .out_valid_o     (out_valid),
    .out_ready_i     (out_ready),
    .pixel_index_o   (pixel_index),
    .red_out_o       (red_out),
    .green_out_o     (green_out),
    .blue_out_o      (blue_out),
    .last_of_run_o   (last_of_run)
  );

  // clock
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // run limit
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("led_gradient_fill_core: mismatch");
      $finish;
    end
  end

  // idle length: mostly none or short, now and then long
  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 10);
    return $urandom_range(15, 30);
  endfunction

  // colour level, biased towards the ends of the range
  function automatic logic [ColW-1:0] pick_level();
    int unsigned roll;
    roll = $urandom_range(0, 9);
    if (roll == 0) return '0;
    if (roll == 1) return '1;
    return ColW'($urandom_range(0, 255));
  endfunction

  // weighted mix of two channel values, weight in 1/1024 steps
  function automatic logic [ColW-1:0] mix_channel(int unsigned from_c, int unsigned to_c,
                                                  int unsigned w);
    return ColW'(((MixScale - w) * from_c + w * to_c) / MixScale);
  endfunction

  // expected pixel writes for one accepted stop; moves the reference stop
  function automatic void predict_fill(logic sof, logic [PosW-1:0] pos_raw,
                                       logic [ColW-1:0] r, logic [ColW-1:0] g,
                                       logic [ColW-1:0] b);
    int unsigned  pos;
    int unsigned  span;
    int unsigned  w;
    pixel_write_t px;
    pos = pos_raw;
    if (pos > LedCount - 1) pos = LedCount - 1;
    if (sof) begin
      px = '{index: PosW'(pos), red: r, green: g, blue: b, last_px: 1'b1};
      pending_pixels.push_back(px);
    end else if (pos > ref_pos) begin
      span = pos - ref_pos;
      for (int unsigned k = ref_pos + 1; k <= pos; k++) begin
        w = ((k - ref_pos) * MixScale) / span;
        px.index   = PosW'(k);
        px.red     = mix_channel(ref_red, r, w);
        px.green   = mix_channel(ref_green, g, w);
        px.blue    = mix_channel(ref_blue, b, w);
        px.last_px = (k == pos);
        pending_pixels.push_back(px);
      end
    end
    ref_pos   = PosW'(pos);
    ref_red   = r;
    ref_green = g;
    ref_blue  = b;
  endfunction

  // receiver side: random stalls while idling is on
  always @(posedge clk_i) begin
    if (!idle_en) begin
      out_ready  <= 1'b1;
      ready_hold <= 0;
    end else if (ready_hold != 0) begin
      ready_hold <= ready_hold - 1;
    end else if (out_ready) begin
      out_ready  <= 1'b0;
      ready_hold <= pick_gap();
    end else begin
      out_ready  <= 1'b1;
      ready_hold <= $urandom_range(0, 15);
    end
  end

  // check each accepted pixel word against the oldest expectation
  always @(negedge clk_i) begin
    pixel_write_t want;
    if (rst_ni && out_valid && out_ready) begin
      if (pending_pixels.size() == 0) begin
        $error("unexpected pixel write: index %0d", pixel_index);
        fail_count++;
      end else begin
        want = pending_pixels.pop_front();
        if (pixel_index !== want.index) begin
          $error("pixel_index: expected %0d, got %0d", want.index, pixel_index);
          fail_count++;
        end
        if (red_out !== want.red) begin
          $error("red_out: expected %0d, got %0d", want.red, red_out);
          fail_count++;
        end
        if (green_out !== want.green) begin
          $error("green_out: expected %0d, got %0d", want.green, green_out);
          fail_count++;
        end
        if (blue_out !== want.blue) begin
          $error("blue_out: expected %0d, got %0d", want.blue, blue_out);
          fail_count++;
        end
        if (last_of_run !== want.last_px) begin
          $error("last_of_run: expected %0d, got %0d", want.last_px, last_of_run);
          fail_count++;
        end
      end
    end
  end

  // send one stop word; entered and left at a rising edge
  task automatic send_stop(logic sof, logic [PosW-1:0] pos, logic [ColW-1:0] r,
                           logic [ColW-1:0] g, logic [ColW-1:0] b);
    int unsigned gap;
    in_valid <= 1'b1;
    sof_in   <= sof;
    pos_in   <= pos;
    red_in   <= r;
    green_in <= g;
    blue_in  <= b;
    @(negedge clk_i);
    while (!in_ready) @(negedge clk_i);
    predict_fill(sof, pos, r, g, b);
    @(posedge clk_i);
    gap = idle_en ? pick_gap() : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // a later stop straight after reset blends from position 0 in black
  task automatic test_reset_reference();
    send_stop(1'b0, 6'd5, 8'd255, 8'd128, 8'd1);
  endtask

  // frame start writes only its own pixel, at both ends of the strip and in the middle
  task automatic test_frame_start();
    send_stop(1'b1, 6'd63, 8'd255, 8'd255, 8'd255);
    send_stop(1'b1, 6'd0, 8'd0, 8'd0, 8'd0);
    send_stop(1'b1, 6'd31, 8'hAA, 8'h55, 8'hAA);
  endtask

  // full strip run, widest span
  task automatic test_full_span();
    send_stop(1'b1, 6'd0, 8'd255, 8'd0, 8'd255);
    send_stop(1'b0, 6'd63, 8'd0, 8'd255, 8'd0);
  endtask

  // stops at or behind the reference only move it; the stops after them blend from the moved one
  task automatic test_backwards();
    send_stop(1'b1, 6'd40, 8'd10, 8'd20, 8'd30);
    send_stop(1'b0, 6'd40, 8'd200, 8'd100, 8'd50);
    send_stop(1'b0, 6'd10, 8'd1, 8'd2, 8'd3);
    send_stop(1'b0, 6'd11, 8'd254, 8'd253, 8'd252);
    send_stop(1'b0, 6'd63, 8'd0, 8'd128, 8'd255);
  endtask

  // channel extremes, short spans and a chain of stops
  task automatic test_colour_extremes();
    send_stop(1'b1, 6'd0, 8'd0, 8'd0, 8'd0);
    send_stop(1'b0, 6'd3, 8'd255, 8'd255, 8'd255);
    send_stop(1'b0, 6'd7, 8'd0, 8'd0, 8'd0);
    send_stop(1'b0, 6'd8, 8'd255, 8'd0, 8'd128);
    send_stop(1'b0, 6'd0, 8'd77, 8'd88, 8'd99);
  endtask

  // random frames: start then rising stops, with noise and broken sequences
  task automatic test_random_frames();
    int unsigned sent;
    int unsigned pos;
    int unsigned n_stops;
    int unsigned roll;
    sent = 0;
    while (sent < RandomStops) begin
      idle_en <= ($urandom_range(0, 7) != 0);
      if ($urandom_range(0, 9) < 2) begin
        send_stop(1'($urandom_range(0, 1)), PosW'($urandom_range(0, 63)),
                  pick_level(), pick_level(), pick_level());
        sent++;
      end else begin
        pos = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 63) : $urandom_range(0, 20);
        send_stop(1'b1, PosW'(pos), pick_level(), pick_level(), pick_level());
        sent++;
        n_stops = $urandom_range(1, 6);
        for (int unsigned i = 0; i < n_stops; i++) begin
          roll = $urandom_range(0, 19);
          if (roll == 0) begin
            pos = $urandom_range(0, 63);
          end else if (roll < 3) begin
            if (pos < 63) pos = pos + $urandom_range(1, 63 - pos);
          end else begin
            pos = pos + $urandom_range(1, 8);
            if (pos > 63) pos = 63;
          end
          send_stop(1'b0, PosW'(pos), pick_level(), pick_level(), pick_level());
          sent++;
        end
      end
    end
  endtask

  // sequence of tests and final verdict
  initial begin
    ref_pos   = '0;
    ref_red   = '0;
    ref_green = '0;
    ref_blue  = '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_reference();
    test_frame_start();
    test_full_span();
    test_backwards();
    test_colour_extremes();
    test_random_frames();

    in_valid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk_i);
    repeat (TailCycles) @(posedge clk_i);

    if (fail_count == 0 && pending_pixels.size() == 0) begin
      $display("led_gradient_fill_core: match");
    end else begin
      $display("led_gradient_fill_core: mismatch");
    end
    $finish;
  end

endmodule
